@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL that checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/srs_pkg.sv @@
// Shared types, constants and codes of the stencil relaxation solver
`timescale 1ns / 1ps
package srs_pkg;

    localparam int VALUE_W  = 24;
    localparam int SUM_W    = VALUE_W + 2;
    localparam int DIFF_W   = VALUE_W + 3;
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int ACC_W    = 64;
    localparam int TOL_W    = 32;
    localparam int CNT_W    = 16;
    localparam int SIDE_W   = 7;
    localparam int IDX_W    = 12;
    localparam int OP_W     = 2;
    localparam int CFG_IX_W = 3;
    localparam int CFG_D_W  = 32;
    localparam int MAX_GRID_SIDE_DEF = 64;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [1:0] METH_GS  = 2'd0;
    localparam logic [1:0] METH_JAC = 2'd1;
    localparam logic [1:0] METH_RB  = 2'd2;

    localparam logic [CFG_IX_W-1:0] CFG_METHOD    = 3'd0;
    localparam logic [CFG_IX_W-1:0] CFG_SIDE      = 3'd1;
    localparam logic [CFG_IX_W-1:0] CFG_STOP_MODE = 3'd2;
    localparam logic [CFG_IX_W-1:0] CFG_SWEEPS    = 3'd3;
    localparam logic [CFG_IX_W-1:0] CFG_INTERVAL  = 3'd4;
    localparam logic [CFG_IX_W-1:0] CFG_TOL       = 3'd5;
    localparam logic [CFG_IX_W-1:0] CFG_MAX       = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0]           opcode;
        logic [IDX_W-1:0]          cell_index;
        logic signed [VALUE_W-1:0] cell_value;
    } t_in_req;

    typedef struct packed {
        logic                      result_kind;
        logic signed [VALUE_W-1:0] read_value;
        logic [CNT_W-1:0]          sweeps_done;
        logic                      limit_reached;
    } t_out_rsp;

    typedef enum logic [4:0] {
        ST_IDLE, ST_START, ST_SWEEP_CHK, ST_SWEEP_GO, ST_DEFECT_GO,
        ST_CELL, ST_READ, ST_DRAIN, ST_WRITE, ST_SQUARE, ST_ACCUM,
        ST_COPY_RD, ST_COPY_WR, ST_NEXT, ST_SWEPT, ST_INIT,
        ST_MUL_LO, ST_MUL_HI, ST_THRESH, ST_CHECK, ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        PASS_GS, PASS_RB, PASS_JAC, PASS_COPY, PASS_DEFECT
    } t_pass;

    typedef struct packed {
        logic clear;
        logic sq_en;
        logic acc_en;
        logic init_en;
        logic mul_lo;
        logic mul_hi;
        logic thr_en;
    } t_dfct_ctrl;

endpackage

@@ hdl/srs_cell_mem.sv @@
// Synchronous cell memory, one write and one registered read per cycle
`timescale 1ns / 1ps
module srs_cell_mem #(
    parameter int DEPTH = srs_pkg::MAX_GRID_SIDE_DEF * srs_pkg::MAX_GRID_SIDE_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [srs_pkg::VALUE_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [srs_pkg::VALUE_W-1:0] o_rdata
);

    logic [srs_pkg::VALUE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ hdl/srs_defect.sv @@
// Squared-defect accumulator and convergence threshold unit
`timescale 1ns / 1ps
module srs_defect (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  srs_pkg::t_dfct_ctrl               i_ctrl,
    input  logic signed [srs_pkg::DIFF_W-1:0] i_diff,
    input  logic [srs_pkg::TOL_W-1:0]         i_tol,
    output logic                              o_acc_zero,
    output logic                              o_converged
);

    logic [srs_pkg::SQ_W-1:0]      r_sq;
    logic [srs_pkg::ACC_W-1:0]     r_acc;
    logic [srs_pkg::ACC_W-1:0]     r_init;
    logic [srs_pkg::ACC_W-1:0]     r_plo;
    logic [srs_pkg::ACC_W-1:0]     r_phi;
    logic [srs_pkg::ACC_W-1:0]     r_thr;
    logic [srs_pkg::ACC_W:0]       w_sum;
    logic signed [srs_pkg::SQ_W-1:0] w_prod;

    assign w_prod = i_diff * i_diff;
    assign w_sum  = {1'b0, r_acc} + (srs_pkg::ACC_W + 1)'(r_sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_init <= '0;
        end else begin
            if (i_ctrl.clear) begin
                r_acc <= '0;
            end else if (i_ctrl.acc_en) begin
                // saturate at all ones
                r_acc <= w_sum[srs_pkg::ACC_W] ? '1 : w_sum[srs_pkg::ACC_W-1:0];
            end
            if (i_ctrl.init_en) begin
                r_init <= r_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.sq_en) begin
            r_sq <= unsigned'(w_prod);
        end
        if (i_ctrl.mul_lo) begin
            r_plo <= r_init[31:0] * i_tol;
        end
        if (i_ctrl.mul_hi) begin
            r_phi <= r_init[63:32] * i_tol;
        end
        if (i_ctrl.thr_en) begin
            // upper 64 bits of tol * init; low word of the left side is zero
            r_thr <= r_phi + srs_pkg::ACC_W'(r_plo[63:32]);
        end
    end

    assign o_acc_zero  = (r_acc == '0);
    assign o_converged = (r_acc <= r_thr);

endmodule

@@ hdl/stencil_relaxation_solver.sv @@
// Top level of the five-point stencil relaxation solver
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | i_in_valid, o_in_ready, i_in_req     | request in
//   out     | o_out_valid, i_out_ready, o_out_rsp  | result out
//   cfg     | i_cfg_valid, o_cfg_ready, i_cfg_*    | register write
//
// A cell write goes straight into the grid memory; a cell read passes the registered memory
// read, then the output register, and no new request is taken while a read is in flight.
// A start request walks the interior cells in turn in each update, defect and Jacobi copy
// pass; update and defect passes read the neighbours one at a time through the single
// read port of the grid memory.
// Reset is synchronous and active low; memories are not cleared.
// A stalled output holds the sequencer in its result state and blocks new requests.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stencil_relaxation_solver #(
    parameter int MAX_GRID_SIDE = srs_pkg::MAX_GRID_SIDE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  srs_pkg::t_in_req              i_in_req,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output srs_pkg::t_out_rsp             o_out_rsp,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [srs_pkg::CFG_IX_W-1:0]  i_cfg_index,
    input  logic [srs_pkg::CFG_D_W-1:0]   i_cfg_data
);

    localparam int DEPTH = MAX_GRID_SIDE * MAX_GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = 2 * srs_pkg::SIDE_W;
    localparam int SW    = srs_pkg::SIDE_W;
    localparam int CW    = srs_pkg::CNT_W;
    localparam int VW    = srs_pkg::VALUE_W;

    // configuration registers
    logic [1:0]               r_method;
    logic [SW-1:0]            r_grid_side;
    logic                     r_stop_mode;
    logic [CW-1:0]            r_sweep_count;
    logic [CW-1:0]            r_interval;
    logic [srs_pkg::TOL_W-1:0] r_tol;
    logic [CW-1:0]            r_max_sweeps;

    // sequencer state
    srs_pkg::t_state          r_state, n_state;
    srs_pkg::t_pass           r_pass;
    logic                     r_rb_even;
    logic                     r_first;
    logic [SW-1:0]            r_row, r_col;
    logic [IW-1:0]            r_ctr;
    logic [2:0]               r_k, r_kd;
    logic                     r_nb_pend;
    logic                     r_rd_pend;
    logic signed [srs_pkg::SUM_W-1:0] r_sum;
    logic signed [VW-1:0]     r_cval;
    logic [CW-1:0]            r_sweeps;
    logic [CW-1:0]            r_run_left;
    logic                     r_limit;
    logic                     r_out_valid;
    srs_pkg::t_out_rsp        r_out;

    // combinational
    logic [SW-1:0]            w_side;
    logic [IW-1:0]            w_side_x, w_cells, w_in_idx, w_nb_addr;
    logic                     w_tiny, w_in_ok, w_in_acc, w_out_free;
    logic                     w_col_last, w_row_last, w_skip;
    logic [2:0]               w_k_last;
    logic [CW-1:0]            w_group, w_remain;
    logic                     g_we, s_we;
    logic [AW-1:0]            g_waddr, g_raddr, s_waddr, s_raddr;
    logic [VW-1:0]            g_wdata, g_rdata, s_wdata, s_rdata;
    logic signed [srs_pkg::DIFF_W-1:0] w_diff;
    srs_pkg::t_dfct_ctrl      w_dctl;
    logic                     w_acc_zero, w_conv;
    logic                     w_out_load;
    srs_pkg::t_out_rsp        w_out_next;

    // clamp the side to the memory size
    assign w_side   = (int'(r_grid_side) > MAX_GRID_SIDE) ? SW'(MAX_GRID_SIDE) : r_grid_side;
    assign w_tiny   = (w_side < SW'(3));
    assign w_side_x = IW'(w_side);
    assign w_cells  = w_side_x * w_side_x;
    assign w_in_idx = IW'(i_in_req.cell_index);
    assign w_in_ok  = (w_in_idx < w_cells);

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == srs_pkg::ST_IDLE) && !r_rd_pend && w_out_free;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign w_col_last = (r_col == w_side - SW'(2));
    assign w_row_last = (r_row == w_side - SW'(2));
    // red-black: odd cells in the first half sweep, even in the second
    assign w_skip     = (r_pass == srs_pkg::PASS_RB) && ((r_row[0] ^ r_col[0]) == r_rb_even);
    assign w_k_last   = (r_pass == srs_pkg::PASS_DEFECT) ? 3'd4 : 3'd3;

    assign w_group  = (r_interval == '0) ? CW'(1) : r_interval;
    assign w_remain = r_max_sweeps - r_sweeps;

    always_comb begin
        unique case (r_k)
            3'd0:    w_nb_addr = r_ctr - w_side_x;
            3'd1:    w_nb_addr = r_ctr - IW'(1);
            3'd2:    w_nb_addr = r_ctr + IW'(1);
            3'd3:    w_nb_addr = r_ctr + w_side_x;
            default: w_nb_addr = r_ctr;
        endcase
    end

    assign w_diff = (srs_pkg::DIFF_W'(r_cval) <<< 2) - srs_pkg::DIFF_W'(r_sum);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srs_pkg::ST_IDLE: begin
                if (w_in_acc && i_in_req.opcode == srs_pkg::OP_START) begin
                    n_state = srs_pkg::ST_START;
                end
            end
            srs_pkg::ST_START: begin
                if (w_tiny) begin
                    n_state = srs_pkg::ST_DONE;
                end else if (!r_stop_mode) begin
                    n_state = srs_pkg::ST_SWEEP_CHK;
                end else begin
                    n_state = srs_pkg::ST_DEFECT_GO;
                end
            end
            srs_pkg::ST_SWEEP_CHK: begin
                n_state = (r_sweeps == r_sweep_count) ? srs_pkg::ST_DONE
                                                      : srs_pkg::ST_SWEEP_GO;
            end
            srs_pkg::ST_SWEEP_GO:  n_state = srs_pkg::ST_CELL;
            srs_pkg::ST_DEFECT_GO: n_state = srs_pkg::ST_CELL;
            srs_pkg::ST_CELL: begin
                if (w_skip) begin
                    n_state = srs_pkg::ST_NEXT;
                end else if (r_pass == srs_pkg::PASS_COPY) begin
                    n_state = srs_pkg::ST_COPY_RD;
                end else begin
                    n_state = srs_pkg::ST_READ;
                end
            end
            srs_pkg::ST_READ: begin
                if (r_k == w_k_last) begin
                    n_state = srs_pkg::ST_DRAIN;
                end
            end
            srs_pkg::ST_DRAIN: begin
                n_state = (r_pass == srs_pkg::PASS_DEFECT) ? srs_pkg::ST_SQUARE
                                                           : srs_pkg::ST_WRITE;
            end
            srs_pkg::ST_WRITE:   n_state = srs_pkg::ST_NEXT;
            srs_pkg::ST_SQUARE:  n_state = srs_pkg::ST_ACCUM;
            srs_pkg::ST_ACCUM:   n_state = srs_pkg::ST_NEXT;
            srs_pkg::ST_COPY_RD: n_state = srs_pkg::ST_COPY_WR;
            srs_pkg::ST_COPY_WR: n_state = srs_pkg::ST_NEXT;
            srs_pkg::ST_NEXT: begin
                if (!(w_col_last && w_row_last)) begin
                    n_state = srs_pkg::ST_CELL;
                end else begin
                    priority case (r_pass)
                        srs_pkg::PASS_JAC: n_state = srs_pkg::ST_CELL;
                        srs_pkg::PASS_RB: begin
                            n_state = r_rb_even ? srs_pkg::ST_SWEPT : srs_pkg::ST_CELL;
                        end
                        srs_pkg::PASS_DEFECT: begin
                            n_state = r_first ? srs_pkg::ST_INIT : srs_pkg::ST_CHECK;
                        end
                        default: n_state = srs_pkg::ST_SWEPT;
                    endcase
                end
            end
            srs_pkg::ST_SWEPT: begin
                if (!r_stop_mode) begin
                    n_state = srs_pkg::ST_SWEEP_CHK;
                end else if (r_run_left == CW'(1)) begin
                    n_state = srs_pkg::ST_DEFECT_GO;
                end else begin
                    n_state = srs_pkg::ST_SWEEP_GO;
                end
            end
            srs_pkg::ST_INIT: begin
                n_state = w_acc_zero ? srs_pkg::ST_DONE : srs_pkg::ST_MUL_LO;
            end
            srs_pkg::ST_MUL_LO: n_state = srs_pkg::ST_MUL_HI;
            srs_pkg::ST_MUL_HI: n_state = srs_pkg::ST_THRESH;
            srs_pkg::ST_THRESH: n_state = srs_pkg::ST_CHECK;
            srs_pkg::ST_CHECK: begin
                if (w_conv || r_sweeps >= r_max_sweeps) begin
                    n_state = srs_pkg::ST_DONE;
                end else begin
                    n_state = srs_pkg::ST_SWEEP_GO;
                end
            end
            srs_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = srs_pkg::ST_IDLE;
                end
            end
            default: n_state = srs_pkg::ST_IDLE;
        endcase
    end

    // memory ports, defect unit controls and the output register load
    always_comb begin
        g_we       = 1'b0;
        g_waddr    = AW'(r_ctr);
        g_wdata    = VW'(r_sum >>> 2);
        g_raddr    = AW'(w_nb_addr);
        s_we       = 1'b0;
        s_waddr    = AW'(r_ctr);
        s_wdata    = VW'(r_sum >>> 2);
        s_raddr    = AW'(r_ctr);
        w_dctl     = '0;
        w_out_load = 1'b0;
        w_out_next = '0;
        unique case (r_state)
            srs_pkg::ST_IDLE: begin
                g_raddr = AW'(w_in_idx);
                g_waddr = AW'(w_in_idx);
                g_wdata = i_in_req.cell_value;
                g_we    = w_in_acc && w_in_ok && (i_in_req.opcode == srs_pkg::OP_WRITE);
                if (r_rd_pend) begin
                    w_out_load            = 1'b1;
                    w_out_next.read_value = g_rdata;
                end
            end
            srs_pkg::ST_DEFECT_GO: w_dctl.clear = 1'b1;
            srs_pkg::ST_WRITE: begin
                if (r_pass == srs_pkg::PASS_JAC) begin
                    s_we = 1'b1;
                end else begin
                    g_we = 1'b1;
                end
            end
            srs_pkg::ST_SQUARE:  w_dctl.sq_en = 1'b1;
            srs_pkg::ST_ACCUM:   w_dctl.acc_en = 1'b1;
            srs_pkg::ST_COPY_WR: begin
                g_we    = 1'b1;
                g_wdata = s_rdata;
            end
            srs_pkg::ST_INIT:   w_dctl.init_en = 1'b1;
            srs_pkg::ST_MUL_LO: w_dctl.mul_lo = 1'b1;
            srs_pkg::ST_MUL_HI: w_dctl.mul_hi = 1'b1;
            srs_pkg::ST_THRESH: w_dctl.thr_en = 1'b1;
            srs_pkg::ST_DONE: begin
                w_out_load                = w_out_free;
                w_out_next.result_kind    = 1'b1;
                w_out_next.sweeps_done    = r_sweeps;
                w_out_next.limit_reached  = r_limit;
            end
            default: begin
            end
        endcase
    end

    srs_cell_mem #(.DEPTH(DEPTH), .AW(AW)) u_grid (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    srs_cell_mem #(.DEPTH(DEPTH), .AW(AW)) u_scratch (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    srs_defect u_defect (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_dctl),
        .i_diff      (w_diff),
        .i_tol       (r_tol),
        .o_acc_zero  (w_acc_zero),
        .o_converged (w_conv)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method      <= srs_pkg::METH_GS;
            r_grid_side   <= SW'(64);
            r_stop_mode   <= 1'b0;
            r_sweep_count <= CW'(100);
            r_interval    <= CW'(10);
            r_tol         <= srs_pkg::TOL_W'(4295);
            r_max_sweeps  <= CW'(65535);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                srs_pkg::CFG_METHOD:    r_method      <= i_cfg_data[1:0];
                srs_pkg::CFG_SIDE:      r_grid_side   <= i_cfg_data[SW-1:0];
                srs_pkg::CFG_STOP_MODE: r_stop_mode   <= i_cfg_data[0];
                srs_pkg::CFG_SWEEPS:    r_sweep_count <= i_cfg_data[CW-1:0];
                srs_pkg::CFG_INTERVAL:  r_interval    <= i_cfg_data[CW-1:0];
                srs_pkg::CFG_TOL:       r_tol         <= i_cfg_data[srs_pkg::TOL_W-1:0];
                srs_pkg::CFG_MAX:       r_max_sweeps  <= i_cfg_data[CW-1:0];
                default: begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srs_pkg::ST_IDLE;
            r_rd_pend   <= 1'b0;
            r_nb_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_sweeps    <= '0;
            r_limit     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= w_in_acc && w_in_ok && (i_in_req.opcode == srs_pkg::OP_READ);
            r_nb_pend <= (r_state == srs_pkg::ST_READ);
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == srs_pkg::ST_START) begin
                r_limit  <= 1'b0;
                r_sweeps <= (w_tiny && !r_stop_mode) ? r_sweep_count : '0;
            end else if (r_state == srs_pkg::ST_SWEPT) begin
                r_sweeps <= r_sweeps + CW'(1);
            end else if (r_state == srs_pkg::ST_CHECK && !w_conv
                         && r_sweeps >= r_max_sweeps) begin
                r_limit <= 1'b1;
            end
        end
    end

    // datapath and walk registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_out_next;
        end
        if (r_nb_pend) begin
            if (r_kd == 3'd4) begin
                r_cval <= signed'(g_rdata);
            end else begin
                r_sum <= r_sum + srs_pkg::SUM_W'(signed'(g_rdata));
            end
        end
        unique case (r_state)
            srs_pkg::ST_START: r_first <= 1'b1;
            srs_pkg::ST_SWEEP_GO: begin
                priority case (r_method)
                    srs_pkg::METH_JAC: r_pass <= srs_pkg::PASS_JAC;
                    srs_pkg::METH_RB:  r_pass <= srs_pkg::PASS_RB;
                    default:           r_pass <= srs_pkg::PASS_GS;
                endcase
                r_rb_even <= 1'b0;
                r_row     <= SW'(1);
                r_col     <= SW'(1);
            end
            srs_pkg::ST_DEFECT_GO: begin
                r_pass <= srs_pkg::PASS_DEFECT;
                r_row  <= SW'(1);
                r_col  <= SW'(1);
            end
            srs_pkg::ST_CELL: begin
                r_ctr <= IW'(r_row) * w_side_x + IW'(r_col);
                r_k   <= 3'd0;
                r_sum <= '0;
            end
            srs_pkg::ST_READ: begin
                r_kd <= r_k;
                r_k  <= r_k + 3'd1;
            end
            srs_pkg::ST_NEXT: begin
                if (!w_col_last) begin
                    r_col <= r_col + SW'(1);
                end else if (!w_row_last) begin
                    r_col <= SW'(1);
                    r_row <= r_row + SW'(1);
                end else begin
                    // end of pass: restart the walk for the follow-on pass
                    r_col <= SW'(1);
                    r_row <= SW'(1);
                    if (r_pass == srs_pkg::PASS_JAC) begin
                        r_pass <= srs_pkg::PASS_COPY;
                    end
                    if (r_pass == srs_pkg::PASS_RB) begin
                        r_rb_even <= 1'b1;
                    end
                end
            end
            srs_pkg::ST_SWEPT: r_run_left <= r_run_left - CW'(1);
            srs_pkg::ST_INIT:  r_first <= 1'b0;
            srs_pkg::ST_CHECK: begin
                r_run_left <= (w_remain < w_group) ? w_remain : w_group;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    // a start request always enters the solve
    `ASSERT_NEXT(a_start_enters, i_clk, i_rst_n, w_in_acc && i_in_req.opcode == srs_pkg::OP_START, r_state == srs_pkg::ST_START, "start request did not start a solve")
    // a pending cell read keeps new requests out
    `ASSERT_SAME(a_rd_blocks, i_clk, i_rst_n, r_rd_pend, !o_in_ready, "request taken while a read is in flight")
    // the limit flag only stands with a full sweep budget used
    `ASSERT_SAME(a_limit_full, i_clk, i_rst_n, r_state == srs_pkg::ST_DONE && r_limit, r_sweeps == r_max_sweeps, "limit flagged below the sweep limit")

endmodule
